// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the watchpoint table.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/mwt_pkg.sv -----
// Types and codes of the memory watchpoint table.
// Depends on nothing; used by memory_watchpoint_table.
`default_nettype none

package mwt_pkg;

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_CHECK  = 2'd2;

  localparam logic [2:0] STATUS_ADDED     = 3'd0;
  localparam logic [2:0] STATUS_COVERED   = 3'd1;
  localparam logic [2:0] STATUS_FULL      = 3'd2;
  localparam logic [2:0] STATUS_REMOVED   = 3'd3;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;
  localparam logic [2:0] STATUS_MISS      = 3'd5;
  localparam logic [2:0] STATUS_HIT       = 3'd6;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
    logic [31:0] end_address;
    logic        range_mode;
    logic        trap_on_read;
    logic        trap_on_write;
    logic        log_enable;
    logic        break_enable;
    logic        is_write;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] entry_index;
    logic       log_request;
    logic       break_request;
    logic [4:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic brk;
    logic log;
    logic wr;
    logic rd;
    logic rng;
  } flag_t;

  typedef struct packed {
    logic [31:0] start_addr;
    logic [31:0] end_addr;
    flag_t       flags;
  } entry_t;

endpackage

`default_nettype wire

// ----- src/memory_watchpoint_table.sv -----
// Memory watchpoint table: ordered list of address watchpoints in one synchronous memory.
// Depends on mwt_pkg and assert_macros.svh.
// Add and check scan the entries in order and stop at the first match, or scan all entries
// when none matches; a remove looks for an exact start address and shifts later entries down.
// A new word is taken only in the idle state, and a result waits in StFinish until the output
// is free. Reset empties the table at once; memory contents stay undefined until written.
`default_nettype none
`include "assert_macros.svh"

module memory_watchpoint_table #(
  parameter int ENTRIES = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire mwt_pkg::in_word_t in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output mwt_pkg::out_word_t   out_word_o
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StShift,
    StFinish
  } state_e;

  state_e               state_q, state_d;
  mwt_pkg::in_word_t    item_q, item_d;
  logic [CNT_W-1:0]     rd_q, rd_d;
  logic                 inflight_q, inflight_d;
  logic [IDX_W-1:0]     cmp_idx_q, cmp_idx_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     hit_idx_q, hit_idx_d;
  mwt_pkg::flag_t       hit_flags_q, hit_flags_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  mwt_pkg::out_word_t   out_q, out_d;

  mwt_pkg::entry_t      mem [ENTRIES];
  mwt_pkg::entry_t      mem_rdata_q;
  logic                 mem_re;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  mwt_pkg::entry_t      mem_wdata;
  mwt_pkg::entry_t      new_entry;
  logic                 entry_hit;
  logic                 out_free;
  logic                 fits;

  function automatic logic entry_match(mwt_pkg::entry_t e, logic [31:0] a,
                                       logic exact_only);
    logic m;
    if (e.flags.rng && !exact_only) begin
      m = (a >= e.start_addr) && (a <= e.end_addr);
    end else begin
      m = (e.start_addr == a);
    end
    return m;
  endfunction

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= mem[rd_q[IDX_W-1:0]];
    end
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign mem_re      = ((state_q == StScan) || (state_q == StShift)) && (rd_q < count_q);
  assign entry_hit   = inflight_q &&
                       entry_match(mem_rdata_q, item_q.address,
                                   item_q.func == mwt_pkg::FUNC_REMOVE);
  assign fits        = item_q.is_write ? hit_flags_q.wr : hit_flags_q.rd;

  always_comb begin
    new_entry.start_addr  = item_q.address;
    new_entry.end_addr    = item_q.range_mode ? item_q.end_address : item_q.address;
    new_entry.flags.rng   = item_q.range_mode;
    new_entry.flags.rd    = item_q.trap_on_read;
    new_entry.flags.wr    = item_q.trap_on_write;
    new_entry.flags.log   = item_q.log_enable;
    new_entry.flags.brk   = item_q.break_enable;
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    rd_d        = rd_q;
    inflight_d  = inflight_q;
    cmp_idx_d   = cmp_idx_q;
    found_d     = found_q;
    hit_idx_d   = hit_idx_q;
    hit_flags_d = hit_flags_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = cmp_idx_q - IDX_W'(1);
    mem_wdata   = mem_rdata_q;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d     = in_word_i;
          rd_d       = '0;
          inflight_d = 1'b0;
          found_d    = 1'b0;
          if ((in_word_i.func == mwt_pkg::FUNC_ADD) ||
              (in_word_i.func == mwt_pkg::FUNC_REMOVE) ||
              (in_word_i.func == mwt_pkg::FUNC_CHECK)) begin
            state_d = StScan;
          end else begin
            state_d = StFinish;
          end
        end
      end
      StScan: begin
        inflight_d = mem_re;
        cmp_idx_d  = rd_q[IDX_W-1:0];
        if (mem_re) begin
          rd_d = rd_q + CNT_W'(1);
        end
        if (entry_hit) begin
          found_d     = 1'b1;
          hit_idx_d   = cmp_idx_q;
          hit_flags_d = mem_rdata_q.flags;
          if (item_q.func == mwt_pkg::FUNC_REMOVE) begin
            state_d    = StShift;
            rd_d       = CNT_W'(cmp_idx_q) + CNT_W'(1);
            inflight_d = 1'b0;
          end else begin
            state_d = StFinish;
          end
        end else if (!inflight_q && !mem_re) begin
          state_d = StFinish;
        end
      end
      StShift: begin
        mem_we     = inflight_q;
        inflight_d = mem_re;
        cmp_idx_d  = rd_q[IDX_W-1:0];
        if (mem_re) begin
          rd_d = rd_q + CNT_W'(1);
        end else if (!inflight_q) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          state_d           = StIdle;
          out_valid_d       = 1'b1;
          out_d.status      = mwt_pkg::STATUS_MISS;
          out_d.entry_index = '0;
          out_d.log_request   = 1'b0;
          out_d.break_request = 1'b0;
          case (item_q.func)
            mwt_pkg::FUNC_ADD: begin
              if (found_q) begin
                out_d.status      = mwt_pkg::STATUS_COVERED;
                out_d.entry_index = 4'(hit_idx_q);
              end else if (count_q == FULL_COUNT) begin
                out_d.status = mwt_pkg::STATUS_FULL;
              end else begin
                out_d.status      = mwt_pkg::STATUS_ADDED;
                out_d.entry_index = 4'(count_q);
                mem_we            = 1'b1;
                mem_waddr         = count_q[IDX_W-1:0];
                mem_wdata         = new_entry;
                count_d           = count_q + CNT_W'(1);
              end
            end
            mwt_pkg::FUNC_REMOVE: begin
              if (found_q) begin
                out_d.status      = mwt_pkg::STATUS_REMOVED;
                out_d.entry_index = 4'(hit_idx_q);
                count_d           = count_q - CNT_W'(1);
              end else begin
                out_d.status = mwt_pkg::STATUS_NOT_FOUND;
              end
            end
            mwt_pkg::FUNC_CHECK: begin
              if (found_q) begin
                out_d.status        = mwt_pkg::STATUS_HIT;
                out_d.entry_index   = 4'(hit_idx_q);
                out_d.log_request   = fits && hit_flags_q.log;
                out_d.break_request = fits && hit_flags_q.brk;
              end
            end
            default: begin
              out_d.status = mwt_pkg::STATUS_MISS;
            end
          endcase
          out_d.entry_count = 5'(count_d);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      item_q      <= '0;
      rd_q        <= '0;
      inflight_q  <= 1'b0;
      cmp_idx_q   <= '0;
      found_q     <= 1'b0;
      hit_idx_q   <= '0;
      hit_flags_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      rd_q        <= rd_d;
      inflight_q  <= inflight_d;
      cmp_idx_q   <= cmp_idx_d;
      found_q     <= found_d;
      hit_idx_q   <= hit_idx_d;
      hit_flags_q <= hit_flags_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= FULL_COUNT)
  `ASSERT_NEXT(a_count_only_at_finish, clk_i, rst_ni, state_q != StFinish, $stable(count_q))
  `ASSERT_IMPLIES(a_write_phase, clk_i, rst_ni, mem_we,
                  (state_q == StShift) || (state_q == StFinish))
  `ASSERT_IMPLIES(a_shift_is_remove, clk_i, rst_ni, state_q == StShift,
                  found_q && (item_q.func == mwt_pkg::FUNC_REMOVE))

endmodule

`default_nettype wire
